// ----- sv/b85e_pkg.sv -----
`default_nettype none
package b85e_pkg;

	localparam int unsigned DigitBase = 85;
	localparam int unsigned CharOffset = 33;
	localparam int unsigned GroupChars = 5;
	localparam int unsigned FracBits = 58;
	localparam int unsigned AccBits = FracBits + 7;
	localparam longint unsigned Digit4 = 64'd52200625;
	localparam longint unsigned RecipFull = ((64'd1 << FracBits) + Digit4 - 64'd1) / Digit4;
	localparam logic [32:0] Recip = RecipFull[32:0];
	localparam int unsigned QueueDepth = 2;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       final_byte;
	} in_t;

	typedef struct packed {
		logic [6:0] out_char;
		logic       is_last;
	} out_t;

	typedef struct packed {
		logic [31:0] word;
		logic [2:0]  count;
		logic        last;
	} job_t;

	typedef struct packed {
		logic push;
		logic full;
	} q_ctrl_t;

endpackage
`default_nettype wire

// ----- sv/b85e_front.sv -----
`default_nettype none
module b85e_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire b85e_pkg::in_t in_data,
	input  wire logic          q_full,
	output b85e_pkg::q_ctrl_t  q_ctrl,
	output b85e_pkg::job_t     q_job
);

	logic [31:0] word_q;
	logic [1:0]  fill_q;
	logic [31:0] word_next;
	logic        accept;
	logic        close;

	assign in_ready = !q_full;
	assign accept = in_valid && in_ready;
	assign close = (fill_q == 2'd3) || in_data.final_byte;

	always_comb begin
		case (fill_q)
			2'd0: word_next = {in_data.data_byte, word_q[23:0]};
			2'd1: word_next = {word_q[31:24], in_data.data_byte, word_q[15:0]};
			2'd2: word_next = {word_q[31:16], in_data.data_byte, word_q[7:0]};
			2'd3: word_next = {word_q[31:8], in_data.data_byte};
			default: word_next = word_q;
		endcase
	end

	always_comb begin
		q_job.word = word_next;
		q_job.count = (fill_q == 2'd3) ? 3'(b85e_pkg::GroupChars) : {1'b0, fill_q} + 3'd2;
		q_job.last = in_data.final_byte;
		q_ctrl.push = accept && close;
		q_ctrl.full = q_full;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_q <= '0;
			fill_q <= '0;
		end else if (accept) begin
			if (close) begin
				word_q <= '0;
				fill_q <= '0;
			end else begin
				word_q <= word_next;
				fill_q <= fill_q + 2'd1;
			end
		end
	end

endmodule
`default_nettype wire

// ----- sv/b85e_fifo.sv -----
`default_nettype none
module b85e_fifo (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire b85e_pkg::q_ctrl_t  ctrl,
	input  wire b85e_pkg::job_t     push_data,
	output logic                    full,
	input  wire logic               pop,
	output logic                    valid,
	output b85e_pkg::job_t          pop_data
);

	b85e_pkg::job_t mem_q [b85e_pkg::QueueDepth];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       do_push;
	logic       do_pop;

	assign full = (count_q == 2'(b85e_pkg::QueueDepth));
	assign valid = (count_q != 2'd0);
	assign pop_data = mem_q[rd_ptr_q];
	assign do_push = ctrl.push && !full;
	assign do_pop = pop && valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			count_q <= count_q + {1'b0, do_push} - {1'b0, do_pop};
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= 2'(b85e_pkg::QueueDepth))
		else $error("queue count exceeds depth");
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.full |-> !ctrl.push || full)
		else $error("queue full flag mismatch");
`endif

endmodule
`default_nettype wire

// ----- sv/b85e_back.sv -----
`default_nettype none
module b85e_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           q_valid,
	input  wire b85e_pkg::job_t q_job,
	output logic                q_pop,
	output logic                out_valid,
	input  wire logic           out_ready,
	output b85e_pkg::out_t      out_data
);

	localparam int unsigned Fb = b85e_pkg::FracBits;
	localparam int unsigned Ab = b85e_pkg::AccBits;

	logic          s1_valid_q;
	logic [Ab-1:0] prod_s1;
	logic [2:0]    count_s1;
	logic          last_s1;

	logic [Ab-1:0] acc_q;
	logic [2:0]    left_q;
	logic          last_q;

	logic           out_valid_q;
	b85e_pkg::out_t out_q;

	logic          out_free;
	logic          step;
	logic          load;
	logic [Ab-1:0] frac;
	logic [Ab-1:0] acc_next;

	assign out_free = !out_valid_q || out_ready;
	assign step = (left_q != 3'd0) && out_free;
	assign load = s1_valid_q && ((left_q == 3'd0) || (step && (left_q == 3'd1)));
	assign q_pop = q_valid && (!s1_valid_q || load);

	assign frac = {7'd0, acc_q[Fb-1:0]};
	assign acc_next = (frac << 6) + (frac << 4) + (frac << 2) + frac;

	assign out_valid = out_valid_q;
	assign out_data = out_q;

	always_ff @(posedge clk) begin
		if (q_pop) begin
			prod_s1 <= Ab'({33'd0, q_job.word} * {32'd0, b85e_pkg::Recip});
			count_s1 <= q_job.count;
			last_s1 <= q_job.last;
		end
		if (step) begin
			out_q.out_char <= acc_q[Ab-1:Fb] + 7'(b85e_pkg::CharOffset);
			out_q.is_last <= last_q && (left_q == 3'd1);
		end
		if (load) begin
			acc_q <= prod_s1;
			last_q <= last_s1;
		end else if (step) begin
			acc_q <= acc_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			left_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				s1_valid_q <= 1'b1;
			end else if (load) begin
				s1_valid_q <= 1'b0;
			end
			if (load) begin
				left_q <= count_s1;
			end else if (step) begin
				left_q <= left_q - 3'd1;
			end
			if (step) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

`ifndef SYNTHESIS
	a_left_bound: assert property (@(posedge clk) disable iff (!arst_n)
		left_q <= 3'(b85e_pkg::GroupChars))
		else $error("character count out of range");
	a_char_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_q.out_char >= 7'd33) && (out_q.out_char <= 7'd117))
		else $error("character outside the base-85 alphabet");
	a_last_mark: assert property (@(posedge clk) disable iff (!arst_n)
		step && last_q && (left_q == 3'd1) |=> out_valid_q && out_q.is_last)
		else $error("last character not marked");
`endif

endmodule
`default_nettype wire

// ----- sv/base85_stream_encoder_unit.sv -----
`default_nettype none
// Each byte is taken while the group queue has room. A byte that closes a group
// passes the group queue, the product register, the accumulator and the output
// register before its first character leaves. Characters leave at one per cycle
// while out_ready allows, so a full group of 4 bytes gives 5 characters.
// Reset clears all control state at once; no clearing pass is needed.
module base85_stream_encoder_unit (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire b85e_pkg::in_t  in_data,
	output logic                out_valid,
	input  wire logic           out_ready,
	output b85e_pkg::out_t      out_data
);

	b85e_pkg::q_ctrl_t q_ctrl;
	b85e_pkg::job_t    push_job;
	b85e_pkg::job_t    pop_job;
	logic              q_full;
	logic              q_valid;
	logic              q_pop;

	b85e_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.q_full   (q_full),
		.q_ctrl   (q_ctrl),
		.q_job    (push_job)
	);

	b85e_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (q_ctrl),
		.push_data (push_job),
		.full      (q_full),
		.pop       (q_pop),
		.valid     (q_valid),
		.pop_data  (pop_job)
	);

	b85e_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_job     (pop_job),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule
`default_nettype wire
